@@ hdl/pmfb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pmfb_pkg - shared definitions of the paged monochrome framebuffer
// Default geometry, byte constants and operation codes.
// ---------------------------------------------------------------------------
package pmfb_pkg;

	localparam int DISPLAY_WIDTH_DEF  = 128;
	localparam int DISPLAY_HEIGHT_DEF = 64;

	localparam int BYTE_W    = 8;
	localparam int MAX_WORDS = 16;

	localparam logic [BYTE_W-1:0] FILL_ON  = 8'hFF;
	localparam logic [BYTE_W-1:0] FILL_OFF = 8'h00;

	localparam logic [2:0] COLUMN_OFFSET_RESET = 3'd2;

	typedef enum logic [1:0] {
		OP_FILL  = 2'd0,
		OP_PIXEL = 2'd1,
		OP_RECT  = 2'd2,
		OP_READ  = 2'd3
	} op_t;

endpackage
`default_nettype wire

@@ hdl/pmfb_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// pmfb_ram - frame store
// Single-port byte memory, one access per cycle, registered read data.
// ---------------------------------------------------------------------------
module pmfb_ram
	import pmfb_pkg::*;
#(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [AW-1:0]     addr,
	input  wire logic [BYTE_W-1:0] wdata,
	output logic      [BYTE_W-1:0] rdata
);

	logic [BYTE_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

@@ hdl/paged_monochrome_framebuffer_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// paged_monochrome_framebuffer_unit - page-organized monochrome framebuffer
// Fill, pixel, rectangle outline and page readout over a byte frame store.
// ---------------------------------------------------------------------------
// Usage:
//  - Command channel: a transaction is taken at a clock edge with start high
//    and busy low. operation selects fill, pixel, rectangle outline or page
//    readout; the other fields are sampled at that edge only.
//  - Config channel: cfg_ready is always high; cfg_data is the panel column
//    shift. Write it only while busy is low and no readout word is pending.
//  - Result channel: readout words appear for one cycle with word_strobe
//    high. The receiver cannot stall, so every strobe must be taken.
// Operations (store of DEPTH = DISPLAY_WIDTH * (DISPLAY_HEIGHT / 8) bytes):
//  - Pixel: busy after acceptance for a read, then a modify-write.
//  - Fill: busy while every byte of the store is written, one byte per cycle.
//  - Rectangle: a read and a modify-write for both opposite edges at every
//    on-screen column or row walked, plus a bounds check for each walk.
//  - Readout: one byte read per cycle from the single memory port; busy while
//    all words of the page are addressed; each word is strobed after its
//    eighth byte has passed the RAM read register and the output registers.
// Reset: the store is cleared by a sweep over all DEPTH bytes with busy high;
// configuration writes are still taken during that sweep.
// ---------------------------------------------------------------------------
module paged_monochrome_framebuffer_unit
	import pmfb_pkg::*;
#(
	parameter int DISPLAY_WIDTH  = DISPLAY_WIDTH_DEF,
	parameter int DISPLAY_HEIGHT = DISPLAY_HEIGHT_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// command channel
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  operation,
	input  wire logic [7:0]  x_first,
	input  wire logic [7:0]  y_first,
	input  wire logic [7:0]  x_last,
	input  wire logic [7:0]  y_last,
	input  wire logic        color,
	input  wire logic [2:0]  page_select,
	// configuration channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [2:0]  cfg_data,
	// result channel
	output logic             word_strobe,
	output logic [2:0]       page_index,
	output logic [3:0]       chunk_index,
	output logic [63:0]      column_bytes,
	output logic             is_last
);

	localparam int PAGES  = DISPLAY_HEIGHT / 8;
	localparam int DEPTH  = DISPLAY_WIDTH * PAGES;
	localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WORDS0 = (DISPLAY_WIDTH + 7) / 8;
	localparam int WORDS  = (WORDS0 > MAX_WORDS) ? MAX_WORDS : WORDS0;

	localparam logic [8:0]    WIDTH_V   = 9'(DISPLAY_WIDTH);
	localparam logic [7:0]    HEIGHT_V  = 8'(DISPLAY_HEIGHT);
	localparam logic [4:0]    PAGES_V   = 5'(PAGES);
	localparam logic [7:0]    X_MAX     = 8'(DISPLAY_WIDTH - 1);
	localparam logic [7:0]    Y_MAX     = 8'(DISPLAY_HEIGHT - 1);
	localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);
	localparam logic [6:0]    COL_LAST  = 7'(WORDS * 8 - 1);
	localparam logic [3:0]    CHUNK_END = 4'(WORDS - 1);

	typedef enum logic [4:0] {
		ST_CLEAR   = 5'b00001,
		ST_IDLE    = 5'b00010,
		ST_WALK    = 5'b00100,
		ST_PLOT_RD = 5'b01000,
		ST_PLOT_WR = 5'b10000
	} state_t;

	// readout is its own flag so a new command can overlap the last byte
	state_t           state_q;
	logic             read_q;
	logic [AW-1:0]    sweep_q;
	logic [7:0]       fill_q;
	logic [2:0]       col_off_q;

	// command registers
	logic [7:0]       x1_q, y1_q, x2_q, y2_q, xe_q, ye_q, i_q;
	logic             color_q, rect_q, vert_q, side_q;
	logic [2:0]       page_q;
	logic [6:0]       col_q;

	// readout pipeline
	logic             rd_s1;
	logic [6:0]       col_s1;
	logic [63:0]      acc_q;

	// memory port
	logic             ram_we;
	logic [AW-1:0]    ram_addr;
	logic [7:0]       ram_wdata;
	logic [7:0]       ram_rdata;

	// plot datapath
	logic [7:0]       px, py;
	logic [8:0]       pcol;
	logic             plot_ok;
	logic [AW-1:0]    plot_addr;
	logic [7:0]       bit_mask;
	logic [7:0]       plot_byte;
	logic [7:0]       walk_end;
	logic [7:0]       rd_byte;
	logic [63:0]      acc_next;
	logic             accept;

	assign busy      = (state_q != ST_IDLE) || read_q;
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// current plot coordinate: pixel, horizontal edge or vertical edge
	always_comb begin
		px = vert_q ? (side_q ? x2_q : x1_q) : (rect_q ? i_q : x1_q);
		py = vert_q ? i_q : (side_q ? y2_q : y1_q);
	end

	assign pcol      = {1'b0, px} + {6'b0, col_off_q};
	assign plot_ok   = ({1'b0, px} < WIDTH_V) && (py < HEIGHT_V) && (pcol < WIDTH_V) &&
		({2'b0, py[7:3]} < {2'b0, PAGES_V});
	assign plot_addr = AW'(int'(py[7:3]) * DISPLAY_WIDTH + int'(pcol));
	assign bit_mask  = 8'(1) << py[2:0];
	assign plot_byte = color_q ? (ram_rdata | bit_mask) : (ram_rdata & ~bit_mask);
	assign walk_end  = vert_q ? ye_q : xe_q;

	// memory port arbitration by state
	always_comb begin
		ram_we    = 1'b0;
		ram_wdata = plot_byte;
		ram_addr  = plot_addr;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_wdata = fill_q;
				ram_addr  = sweep_q;
			end
			ST_PLOT_WR: begin
				ram_we = plot_ok;
			end
			ST_IDLE: begin
				if (read_q) begin
					ram_addr = AW'(int'(page_q) * DISPLAY_WIDTH + int'(col_q));
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	pmfb_ram #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			read_q    <= 1'b0;
			sweep_q   <= '0;
			fill_q    <= FILL_OFF;
			col_off_q <= COLUMN_OFFSET_RESET;
			i_q       <= '0;
			rect_q    <= 1'b0;
			vert_q    <= 1'b0;
			side_q    <= 1'b0;
			col_q     <= '0;
			rd_s1     <= 1'b0;
			word_strobe <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				col_off_q <= cfg_data;
			end
			// readout: one byte address per cycle
			rd_s1 <= read_q;
			if (read_q) begin
				col_q <= col_q + 7'd1;
				if (col_q == COL_LAST) begin
					read_q <= 1'b0;
				end
			end
			word_strobe <= rd_s1 && (col_s1[2:0] == 3'd7);

			case (state_q)
				ST_CLEAR: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == ADDR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (op_t'(operation))
							OP_FILL: begin
								fill_q  <= color ? FILL_ON : FILL_OFF;
								sweep_q <= '0;
								state_q <= ST_CLEAR;
							end
							OP_PIXEL: begin
								rect_q  <= 1'b0;
								vert_q  <= 1'b0;
								side_q  <= 1'b0;
								state_q <= ST_PLOT_RD;
							end
							OP_RECT: begin
								rect_q  <= 1'b1;
								vert_q  <= 1'b0;
								side_q  <= 1'b0;
								i_q     <= x_first;
								state_q <= ST_WALK;
							end
							OP_READ: begin
								if ({2'b0, page_select} < PAGES_V) begin
									col_q  <= '0;
									read_q <= 1'b1;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_WALK: begin
					// skip an empty walk, then move to the vertical edges or finish
					if (i_q <= walk_end) begin
						state_q <= ST_PLOT_RD;
					end else if (!vert_q) begin
						vert_q <= 1'b1;
						i_q    <= y1_q;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_PLOT_RD: begin
					state_q <= ST_PLOT_WR;
				end
				ST_PLOT_WR: begin
					if (!rect_q) begin
						state_q <= ST_IDLE;
					end else if (!side_q) begin
						side_q  <= 1'b1;
						state_q <= ST_PLOT_RD;
					end else begin
						side_q <= 1'b0;
						if (i_q == walk_end) begin
							if (vert_q) begin
								state_q <= ST_IDLE;
							end else begin
								vert_q  <= 1'b1;
								i_q     <= y1_q;
								state_q <= ST_WALK;
							end
						end else begin
							i_q     <= i_q + 8'd1;
							state_q <= ST_PLOT_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// bytes past the right edge read as zero padding
	assign rd_byte  = ({2'b0, col_s1} < WIDTH_V) ? ram_rdata : FILL_OFF;
	assign acc_next = {rd_byte, acc_q[63:8]};

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			x1_q    <= x_first;
			y1_q    <= y_first;
			x2_q    <= x_last;
			y2_q    <= y_last;
			color_q <= color;
			xe_q    <= (x_last < X_MAX) ? x_last : X_MAX;
			ye_q    <= (y_last < Y_MAX) ? y_last : Y_MAX;
			if (op_t'(operation) == OP_READ) begin
				page_q <= page_select;
			end
		end
		col_s1 <= col_q;
		if (rd_s1) begin
			acc_q <= acc_next;
			if (col_s1[2:0] == 3'd7) begin
				column_bytes <= acc_next;
				chunk_index  <= col_s1[6:3];
				is_last      <= (col_s1[6:3] == CHUNK_END);
				page_index   <= page_q;
			end
		end
	end

endmodule
`default_nettype wire
